// ----- src/wrcp_pkg.sv -----
package wrcp_pkg;

   // Parser phases, one-hot
   typedef enum logic [6:0] {
      PH_RIFF = 7'b0000001,
      PH_CHDR = 7'b0000010,
      PH_FMT  = 7'b0000100,
      PH_SKIP = 7'b0001000,
      PH_PCM  = 7'b0010000,
      PH_DONE = 7'b0100000,
      PH_ERR  = 7'b1000000
   } wrcp_phase_type;

   // Reported phase codes
   localparam logic [1:0] PHASE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_PCM    = 2'd1;
   localparam logic [1:0] PHASE_DONE   = 2'd2;
   localparam logic [1:0] PHASE_ERROR  = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_RIFF    = 3'd1;
   localparam logic [2:0] ERR_BAD_WAVE    = 3'd2;
   localparam logic [2:0] ERR_SHORT_FMT   = 3'd3;
   localparam logic [2:0] ERR_NO_FMT      = 3'd4;
   localparam logic [2:0] ERR_UNSUPPORTED = 3'd5;
   localparam logic [2:0] ERR_TRUNCATED   = 3'd6;

   // Chunk tags, little-endian as assembled from the stream
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [32:0] FMT_CORE_LEN = 33'd16;
   localparam logic [3:0]  FMT_LAST_OFF = 4'd15;
   localparam logic [3:0]  RIFF_LAST_POS = 4'd11;
   localparam logic [3:0]  RIFF_LEN = 4'd12;
   localparam logic [3:0]  WAVE_POS = 4'd8;
   localparam logic [3:0]  SIZE_POS = 4'd4;
   localparam logic [2:0]  HDR_LAST_BYTE = 3'd7;

   localparam logic [15:0] PCM_FORMAT = 16'd1;
   localparam logic [15:0] PCM_BITS   = 16'd16;

   // Expected preamble byte; size bytes are not compared
   function automatic logic [7:0] preamble_byte(input logic [3:0] pos);
      logic [7:0] b;
      case (pos)
         4'd0:    b = 8'h52;  // R
         4'd1:    b = 8'h49;  // I
         4'd2:    b = 8'h46;  // F
         4'd3:    b = 8'h46;  // F
         4'd8:    b = 8'h57;  // W
         4'd9:    b = 8'h41;  // A
         4'd10:   b = 8'h56;  // V
         4'd11:   b = 8'h45;  // E
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   typedef struct packed {
      wrcp_phase_type phase;
      logic [3:0]     riff_pos;
      logic [63:0]    hdr;
      logic [2:0]     hdr_cnt;
      logic [32:0]    body_left;
      logic [3:0]     fmt_off;
      logic [15:0]    format;
      logic [15:0]    channels;
      logic [31:0]    rate;
      logic [15:0]    bits;
      logic           fmt_seen;
      logic [31:0]    data_left;
      logic [2:0]     err;
   } wrcp_state_type;

   // Parser state after reset: RIFF preamble, everything else clear
   localparam wrcp_state_type STATE_RESET = '{phase: PH_RIFF, default: '0};

   typedef struct packed {
      logic [1:0]  phase;
      logic        pcm_valid;
      logic [7:0]  pcm_byte;
      logic        pcm_last;
      logic        header_ready;
      logic [2:0]  error_code;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] sample_bits;
      logic [31:0] data_size;
   } wrcp_result_type;

endpackage

// ----- src/wrcp_step.sv -----
module wrcp_step (
   input  wrcp_pkg::wrcp_state_type  state,
   input  logic [7:0]                file_byte,
   input  logic                      end_of_stream,
   input  logic                      require_pcm16,
   output wrcp_pkg::wrcp_state_type  state_next,
   output wrcp_pkg::wrcp_result_type result
);

   wrcp_pkg::wrcp_state_type nxt;
   logic [63:0] hdr_next;
   logic [31:0] hdr_id;
   logic [31:0] hdr_size;
   logic [32:0] padded;
   logic [32:0] body_dec;
   logic [31:0] data_dec;
   logic        valid;
   logic        last;
   logic        ready;
   logic [1:0]  phase_code;

   // Insert the current byte into the chunk header
   always_comb begin
      hdr_next = state.hdr;
      for (int i = 0; i < 8; i++) begin
         if (state.hdr_cnt == 3'(i)) begin
            hdr_next[8*i +: 8] = file_byte;
         end
      end
   end

   assign hdr_id   = hdr_next[31:0];
   assign hdr_size = hdr_next[63:32];
   assign padded   = {1'b0, hdr_size} + {32'd0, hdr_size[0]};
   assign body_dec = state.body_left - {32'd0, (state.body_left != 33'd0)};
   assign data_dec = state.data_left - {31'd0, (state.data_left != 32'd0)};

   // Advance the parser by one byte
   always_comb begin
      nxt   = state;
      valid = 1'b0;
      last  = 1'b0;
      ready = 1'b0;
      unique case (state.phase)
         wrcp_pkg::PH_RIFF: begin
            if (state.riff_pos >= wrcp_pkg::RIFF_LEN) begin
               nxt.err   = wrcp_pkg::ERR_BAD_RIFF;
               nxt.phase = wrcp_pkg::PH_ERR;
            end else if (state.riff_pos < wrcp_pkg::SIZE_POS &&
                         file_byte != wrcp_pkg::preamble_byte(state.riff_pos)) begin
               nxt.err   = wrcp_pkg::ERR_BAD_RIFF;
               nxt.phase = wrcp_pkg::PH_ERR;
            end else if (state.riff_pos >= wrcp_pkg::WAVE_POS &&
                         file_byte != wrcp_pkg::preamble_byte(state.riff_pos)) begin
               nxt.err   = wrcp_pkg::ERR_BAD_WAVE;
               nxt.phase = wrcp_pkg::PH_ERR;
            end else if (state.riff_pos == wrcp_pkg::RIFF_LAST_POS) begin
               nxt.hdr_cnt = 3'd0;
               nxt.phase   = wrcp_pkg::PH_CHDR;
            end else begin
               nxt.riff_pos = state.riff_pos + 4'd1;
            end
         end
         wrcp_pkg::PH_CHDR: begin
            nxt.hdr = hdr_next;
            if (state.hdr_cnt == wrcp_pkg::HDR_LAST_BYTE) begin
               // Dispatch on the completed chunk header
               if (hdr_id == wrcp_pkg::ID_FMT) begin
                  if ({1'b0, hdr_size} < wrcp_pkg::FMT_CORE_LEN) begin
                     nxt.err   = wrcp_pkg::ERR_SHORT_FMT;
                     nxt.phase = wrcp_pkg::PH_ERR;
                  end else begin
                     nxt.fmt_off   = 4'd0;
                     nxt.body_left = padded - wrcp_pkg::FMT_CORE_LEN;
                     nxt.phase     = wrcp_pkg::PH_FMT;
                  end
               end else if (hdr_id == wrcp_pkg::ID_DATA) begin
                  if (!state.fmt_seen) begin
                     nxt.err   = wrcp_pkg::ERR_NO_FMT;
                     nxt.phase = wrcp_pkg::PH_ERR;
                  end else if (require_pcm16 && (state.format != wrcp_pkg::PCM_FORMAT ||
                                                 state.bits != wrcp_pkg::PCM_BITS)) begin
                     nxt.err   = wrcp_pkg::ERR_UNSUPPORTED;
                     nxt.phase = wrcp_pkg::PH_ERR;
                  end else begin
                     ready         = 1'b1;
                     nxt.data_left = hdr_size;
                     nxt.phase     = (hdr_size == 32'd0) ? wrcp_pkg::PH_DONE
                                                         : wrcp_pkg::PH_PCM;
                  end
               end else begin
                  nxt.body_left = padded;
                  if (padded == 33'd0) begin
                     nxt.hdr_cnt = 3'd0;
                     nxt.phase   = wrcp_pkg::PH_CHDR;
                  end else begin
                     nxt.phase = wrcp_pkg::PH_SKIP;
                  end
               end
            end else begin
               nxt.hdr_cnt = state.hdr_cnt + 3'd1;
            end
         end
         wrcp_pkg::PH_FMT: begin
            // Capture the core fmt fields
            case (state.fmt_off)
               4'd0:  nxt.format[7:0]    = file_byte;
               4'd1:  nxt.format[15:8]   = file_byte;
               4'd2:  nxt.channels[7:0]  = file_byte;
               4'd3:  nxt.channels[15:8] = file_byte;
               4'd4:  nxt.rate[7:0]      = file_byte;
               4'd5:  nxt.rate[15:8]     = file_byte;
               4'd6:  nxt.rate[23:16]    = file_byte;
               4'd7:  nxt.rate[31:24]    = file_byte;
               4'd14: nxt.bits[7:0]      = file_byte;
               4'd15: nxt.bits[15:8]     = file_byte;
               default: ;
            endcase
            if (state.fmt_off == wrcp_pkg::FMT_LAST_OFF) begin
               nxt.fmt_seen = 1'b1;
               if (state.body_left == 33'd0) begin
                  nxt.hdr_cnt = 3'd0;
                  nxt.phase   = wrcp_pkg::PH_CHDR;
               end else begin
                  nxt.phase = wrcp_pkg::PH_SKIP;
               end
            end else begin
               nxt.fmt_off = state.fmt_off + 4'd1;
            end
         end
         wrcp_pkg::PH_SKIP: begin
            nxt.body_left = body_dec;
            if (body_dec == 33'd0) begin
               nxt.hdr_cnt = 3'd0;
               nxt.phase   = wrcp_pkg::PH_CHDR;
            end
         end
         wrcp_pkg::PH_PCM: begin
            valid         = 1'b1;
            nxt.data_left = data_dec;
            if (data_dec == 32'd0) begin
               last      = 1'b1;
               nxt.phase = wrcp_pkg::PH_DONE;
            end
         end
         wrcp_pkg::PH_DONE: ;
         wrcp_pkg::PH_ERR:  ;
         default: nxt.phase = wrcp_pkg::PH_ERR;
      endcase

      // Flag a file that ends before the data is complete
      if (end_of_stream && nxt.phase != wrcp_pkg::PH_DONE && nxt.phase != wrcp_pkg::PH_ERR) begin
         nxt.err   = wrcp_pkg::ERR_TRUNCATED;
         nxt.phase = wrcp_pkg::PH_ERR;
      end
   end

   // Map the internal phase to the reported code
   always_comb begin
      unique case (nxt.phase)
         wrcp_pkg::PH_ERR:  phase_code = wrcp_pkg::PHASE_ERROR;
         wrcp_pkg::PH_DONE: phase_code = wrcp_pkg::PHASE_DONE;
         wrcp_pkg::PH_PCM:  phase_code = wrcp_pkg::PHASE_PCM;
         default:           phase_code = wrcp_pkg::PHASE_HEADER;
      endcase
   end

   assign state_next = nxt;

   always_comb begin
      result.phase         = phase_code;
      result.pcm_valid     = valid;
      result.pcm_byte      = valid ? file_byte : 8'd0;
      result.pcm_last      = last;
      result.header_ready  = ready;
      result.error_code    = nxt.err;
      result.audio_format  = nxt.format;
      result.channel_count = nxt.channels;
      result.sample_rate   = nxt.rate;
      result.sample_bits   = nxt.bits;
      result.data_size     = (phase_code == wrcp_pkg::PHASE_PCM ||
                              phase_code == wrcp_pkg::PHASE_DONE) ? nxt.hdr[63:32] : 32'd0;
   end

endmodule

// ----- src/wav_riff_chunk_parser_unit.sv -----
// WAV file parser, one file byte per transfer.
// req channel: tdata[7:0] is the next file byte, tlast marks the final byte of
// the file. rsp channel: exactly one result per input byte, in order; tlast is
// set on the last PCM byte that the data chunk size announced, tuser[0] marks
// a PCM byte, tdata carries phase, byte, header flag, error code, the fmt
// fields and the data size.
// csr_wr_en / csr_wr_data set require_pcm16 (reset value 1); write it only
// while no transfer is in flight.
// The result of a byte is registered and is on rsp in the cycle after its transfer.
// Throughput: one byte per cycle unless the receiver stalls; the parser state
// and result are formed combinationally from the state registers and the byte.
// When the receiver stalls, the result register holds and req_tready drops
// until the result is taken (req_tready = !rsp_tvalid || rsp_tready).
// Reset: synchronous, active high; the parser returns to the RIFF preamble,
// all captured fields and errors clear, and rsp_tvalid goes low. An error is
// held until reset, and so is the done phase; a new file needs a reset.
module wav_riff_chunk_parser_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] file_byte
   input  logic         req_tlast,   // end_of_stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] phase, [9:2] pcm_byte, [10] header_ready, [13:11] error_code,
   // [29:14] audio_format, [45:30] channel_count, [77:46] sample_rate,
   // [93:78] sample_bits, [125:94] data_size, [127:126] zero
   output logic [127:0] rsp_tdata,
   output logic         rsp_tlast,   // pcm_last
   output logic [0:0]   rsp_tuser,   // [0] pcm_valid
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   wrcp_pkg::wrcp_state_type  state_ff;
   wrcp_pkg::wrcp_state_type  state_in;
   wrcp_pkg::wrcp_result_type result_in;
   wrcp_pkg::wrcp_result_type rsp_ff;
   logic                      rsp_valid_ff;
   logic                      require_pcm16_ff;
   logic                      req_transfer;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_transfer = req_tvalid && req_tready;

   wrcp_step u_step (
      .state         (state_ff),
      .file_byte     (req_tdata),
      .end_of_stream (req_tlast),
      .require_pcm16 (require_pcm16_ff),
      .state_next    (state_in),
      .result        (result_in)
   );

   // Hold the configuration bit
   always_ff @(posedge clock) begin
      if (reset) begin
         require_pcm16_ff <= 1'b1;
      end else if (csr_wr_en) begin
         require_pcm16_ff <= csr_wr_data;
      end
   end

   // Advance the parser state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrcp_pkg::STATE_RESET;
      end else if (req_transfer) begin
         state_ff <= state_in;
      end
   end

   // Result register: load on transfer, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_transfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.pcm_last;
   assign rsp_tuser  = rsp_ff.pcm_valid;
   assign rsp_tdata  = {2'b00,
                        rsp_ff.data_size,
                        rsp_ff.sample_bits,
                        rsp_ff.sample_rate,
                        rsp_ff.channel_count,
                        rsp_ff.audio_format,
                        rsp_ff.error_code,
                        rsp_ff.header_ready,
                        rsp_ff.pcm_byte,
                        rsp_ff.phase};

endmodule

// ----- src/wrcp_checker.sv -----
module wrcp_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tlast,
   input logic [0:0]   rsp_tuser
);

   // No result is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // The last PCM byte is a PCM byte and moves the parser to done
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0] && rsp_tdata[1:0] == wrcp_pkg::PHASE_DONE)
      else $error("pcm_last outside a final pcm byte");

   // An error code shows exactly in the error phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[1:0] == wrcp_pkg::PHASE_ERROR) ==
                      (rsp_tdata[13:11] != wrcp_pkg::ERR_NONE)))
      else $error("error code and phase disagree");

   // A data header leaves the header phase: data, done, or a file cut short
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> !rsp_tuser[0] &&
         rsp_tdata[1:0] != wrcp_pkg::PHASE_HEADER)
      else $error("header_ready in the header phase");

endmodule

bind wav_riff_chunk_parser_unit wrcp_checker u_wrcp_checker (.*);
